### hw/rtl/awtm_pkg.sv
package awtm_pkg;

  localparam int NWorkersDef = 16;
  localparam int TimeBits    = 48;
  localparam int MaxRes      = 16;

  localparam logic [4:0]  NumWorkersRst = 5'd16;
  localparam logic [31:0] MarginRst     = 32'd1000000;

  // configuration register indexes
  localparam logic CfgNumWorkers = 1'b0;
  localparam logic CfgMargin     = 1'b1;

  // request types
  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqUpdate = 2'd1;
  localparam logic [1:0] ReqCheck  = 2'd2;

  // result kinds
  localparam logic [1:0] KindRecorded = 2'd0;
  localparam logic [1:0] KindIgnored  = 2'd1;
  localparam logic [1:0] KindFailed   = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [3:0]          worker;
    logic [TimeBits-1:0] time_value;
  } awtm_in_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [3:0]          worker_id;
    logic [TimeBits-1:0] current_threshold;
    logic                last;
  } awtm_out_t;

  typedef enum logic {
    OpDiv,
    OpSqrt
  } awtm_op_e;

  typedef struct packed {
    logic     start;
    awtm_op_e op;
  } awtm_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } awtm_stat_t;

endpackage

### hw/rtl/adaptive_worker_timeout_monitor_unit.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------
// in       | input     | in_valid_i / in_stall_o | awtm_in_t  (req, worker, time)
// out      | output    | out_valid_o/out_stall_i | awtm_out_t (kind, id, thr, last)
// cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An update runs two 64-step divisions and a 32-step square root, all on the
// one shared divide/sqrt unit. A check scans the workers in turn, or skips the
// scan while the threshold is not armed. Reset clears the control state and
// the accumulated statistics; the start-time store is left unset. Output
// stalls hold the sequencer only when it needs the output register; a new
// request is taken while a result waits.
module adaptive_worker_timeout_monitor_unit #(
  parameter int NWORKERS = awtm_pkg::NWorkersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  awtm_pkg::awtm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output awtm_pkg::awtm_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import awtm_pkg::*;

  localparam int AW = (NWORKERS > 1) ? $clog2(NWORKERS) : 1;
  localparam int NW = $clog2(NWORKERS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_D1S  = 4'd2;
  localparam logic [3:0] S_D1W  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_D2S  = 4'd6;
  localparam logic [3:0] S_D2W  = 4'd7;
  localparam logic [3:0] S_RS   = 4'd8;
  localparam logic [3:0] S_RW   = 4'd9;
  localparam logic [3:0] S_THR  = 4'd10;
  localparam logic [3:0] S_PUSH = 4'd11;
  localparam logic [3:0] S_SRD  = 4'd12;
  localparam logic [3:0] S_SCMP = 4'd13;
  localparam logic [3:0] S_SEND = 4'd14;

  logic [3:0] state_q, state_d;

  // configuration
  logic [4:0]  nwork_q;
  logic [31:0] margin_q;
  logic [NW-1:0] n_act;

  // statistics
  logic [31:0] cnt_q;
  logic [63:0] total_q, sqerr_q, prod_q;
  logic [TimeBits-1:0] mean_q, thr_q, span_q;
  logic [31:0] spread_q;
  logic [NWORKERS-1:0] failed_q;

  // request and scan
  awtm_in_t    req_q;
  logic [1:0]  res_kind_q;
  logic [3:0]  res_id_q;
  logic [NW-1:0] idx_q;
  logic [4:0]  k_q;
  logic        pend_v_q;
  logic [3:0]  pend_id_q;

  // output register
  logic      out_v_q;
  awtm_out_t out_q;

  // memory
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [TimeBits-1:0] ram_wdata, st;

  // shared unit
  awtm_cmd_t   cmd;
  awtm_stat_t  stat;
  logic [63:0] unit_res, unit_opnd;

  logic        accept, out_free;
  logic [AW-1:0] req_w;
  logic [64:0] total_sum, sqerr_sum;
  logic [TimeBits-1:0] d_abs, now;
  logic [TimeBits+1:0] thr_sum;
  logic        hit;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_v_q;
  assign req_w    = AW'(req_q.worker);
  assign now      = req_q.time_value;

  // clamp the worker count to 1..NWORKERS
  always_comb begin
    if (nwork_q == 5'd0) begin
      n_act = NW'(1);
    end else if (32'(nwork_q) > NWORKERS) begin
      n_act = NW'(NWORKERS);
    end else begin
      n_act = NW'(nwork_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nwork_q  <= NumWorkersRst;
      margin_q <= MarginRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumWorkers: nwork_q  <= cfg_data_i[4:0];
        CfgMargin:     margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // start-time store: one write port, one registered read port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(in_data_i.worker);
    ram_wdata = in_data_i.time_value;
    if (accept && in_data_i.req_type == ReqLoad &&
        32'(in_data_i.worker) < 32'(n_act)) begin
      ram_we = 1'b1;
    end else if (state_q == S_THR) begin
      ram_we    = 1'b1;
      ram_waddr = req_w;
      ram_wdata = req_q.time_value;
    end
    ram_raddr = (state_q == S_IDLE) ? AW'(in_data_i.worker) : idx_q[AW-1:0];
  end

  awtm_ram #(
    .Width (TimeBits),
    .Depth (NWORKERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (st)
  );

  // the first division takes the freshly summed total, saturated
  always_comb begin
    cmd.start = (state_q == S_D1S) || (state_q == S_D2S) || (state_q == S_RS);
    cmd.op    = (state_q == S_RS) ? OpSqrt : OpDiv;
    case (state_q)
      S_D1S:   unit_opnd = total_sum[64] ? '1 : total_sum[63:0];
      S_D2S:   unit_opnd = sqerr_q;
      default: unit_opnd = unit_res;
    endcase
  end

  awtm_divsqrt u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .operand_i (unit_opnd),
    .divisor_i (cnt_q),
    .res_o     (unit_res),
    .stat_o    (stat)
  );

  assign total_sum = {1'b0, total_q} + {{(65-TimeBits){1'b0}}, span_q};
  assign sqerr_sum = {1'b0, sqerr_q} + {1'b0, prod_q};
  assign d_abs     = (span_q >= mean_q) ? span_q - mean_q : mean_q - span_q;
  assign thr_sum   = {2'b00, mean_q} + (TimeBits+2)'({spread_q, 1'b0})
                     + (TimeBits+2)'(margin_q);
  // worker idle beyond the threshold and not yet failed
  assign hit = !failed_q[idx_q[AW-1:0]] && (now > st) && ((now - st) > thr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == ReqCheck) begin
            state_d = (thr_q == '0) ? S_SEND : S_SRD;
          end else if (in_data_i.req_type == ReqUpdate &&
                       32'(in_data_i.worker) < 32'(n_act)) begin
            state_d = S_UPD;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_UPD:  state_d = (failed_q[req_w] || now <= st) ? S_PUSH : S_D1S;
      S_D1S:  state_d = S_D1W;
      S_D1W:  if (stat.done) state_d = S_SQ;
      S_SQ:   state_d = S_ACC;
      S_ACC:  state_d = S_D2S;
      S_D2S:  state_d = S_D2W;
      S_D2W:  if (stat.done) state_d = S_RS;
      S_RS:   state_d = S_RW;
      S_RW:   if (stat.done) state_d = S_THR;
      S_THR:  state_d = S_PUSH;
      S_PUSH: if (out_free) state_d = S_IDLE;
      S_SRD:  state_d = (idx_q >= n_act || k_q == 5'(MaxRes)) ? S_SEND : S_SCMP;
      S_SCMP: if (!(hit && pend_v_q && !out_free)) state_d = S_SRD;
      S_SEND: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      total_q  <= '0;
      sqerr_q  <= '0;
      mean_q   <= '0;
      spread_q <= '0;
      thr_q    <= '0;
      failed_q <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      idx_q    <= '0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q    <= '0;
            k_q      <= '0;
            pend_v_q <= 1'b0;
          end
        end
        S_UPD: begin
          if (!(failed_q[req_w] || now <= st)) begin
            if (cnt_q != '1) begin
              cnt_q <= cnt_q + 32'd1;
            end
          end
        end
        S_D1S: total_q <= total_sum[64] ? '1 : total_sum[63:0];
        S_D1W: begin
          if (stat.done) begin
            mean_q <= (unit_res[63:TimeBits] != '0) ? '1 : unit_res[TimeBits-1:0];
          end
        end
        S_ACC: sqerr_q <= sqerr_sum[64] ? '1 : sqerr_sum[63:0];
        S_RW:  if (stat.done) spread_q <= unit_res[31:0];
        S_THR: begin
          // arm once enough samples are in
          if (cnt_q >= 32'(n_act >> 1)) begin
            thr_q <= (thr_sum[TimeBits+1:TimeBits] != '0) ? '1
                                                          : thr_sum[TimeBits-1:0];
          end
        end
        S_PUSH: if (out_free) out_v_q <= 1'b1;
        S_SCMP: begin
          if (!(hit && pend_v_q && !out_free)) begin
            idx_q <= idx_q + NW'(1);
            if (hit) begin
              failed_q[idx_q[AW-1:0]] <= 1'b1;
              k_q      <= k_q + 5'd1;
              pend_v_q <= 1'b1;
              if (pend_v_q) begin
                out_v_q <= 1'b1;
              end
            end
          end
        end
        S_SEND: if (out_free) out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_data_i;
      res_kind_q <= KindIgnored;
      res_id_q   <= (in_data_i.req_type == ReqCheck || in_data_i.req_type == 2'd3)
                    ? 4'd0 : in_data_i.worker;
      if (in_data_i.req_type == ReqLoad && 32'(in_data_i.worker) < 32'(n_act)) begin
        res_kind_q <= KindRecorded;
      end
    end
    case (state_q)
      S_UPD: span_q <= now - st;
      S_SQ:  prod_q <= (d_abs[TimeBits-1:32] != '0) ? '1
                       : 64'(d_abs[31:0]) * 64'(d_abs[31:0]);
      S_THR: res_kind_q <= KindRecorded;
      S_PUSH: begin
        if (out_free) begin
          out_q.result_kind       <= res_kind_q;
          out_q.worker_id         <= res_id_q;
          out_q.current_threshold <= thr_q;
          out_q.last              <= 1'b1;
        end
      end
      S_SCMP: begin
        if (!(hit && pend_v_q && !out_free) && hit) begin
          pend_id_q <= 4'(idx_q);
          if (pend_v_q) begin
            out_q.result_kind       <= KindFailed;
            out_q.worker_id         <= pend_id_q;
            out_q.current_threshold <= thr_q;
            out_q.last              <= 1'b0;
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_q.result_kind       <= pend_v_q ? KindFailed : KindRecorded;
          out_q.worker_id         <= pend_v_q ? pend_id_q : 4'd0;
          out_q.current_threshold <= thr_q;
          out_q.last              <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/awtm_ram.sv
module awtm_ram #(
  parameter int Width = 48,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/awtm_divsqrt.sv
module awtm_divsqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awtm_pkg::awtm_cmd_t cmd_i,
  input  logic [63:0]         operand_i,
  input  logic [31:0]         divisor_i,
  output logic [63:0]         res_o,
  output awtm_pkg::awtm_stat_t stat_o
);
  import awtm_pkg::*;

  // Shared restoring step: one quotient bit (divide) or one root bit (sqrt) per cycle.
  awtm_op_e    op_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] acc_q, quo_q;
  logic [35:0] rem_q;
  logic [31:0] dvs_q;

  logic [35:0] rem_sh, trial;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    if (op_q == OpSqrt) begin
      rem_sh = {rem_q[33:0], acc_q[63:62]};
      trial  = {2'b00, quo_q[31:0], 2'b01};
    end else begin
      rem_sh = {rem_q[34:0], acc_q[63]};
      trial  = {4'b0000, dvs_q};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (cmd_i.op == OpSqrt) ? 7'd32 : 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      acc_q <= operand_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      acc_q <= (op_q == OpSqrt) ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
      rem_q <= ge ? diff[35:0] : rem_sh;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign res_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hw/rtl/awtm_checker.sv
module awtm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input awtm_pkg::awtm_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input awtm_pkg::awtm_out_t out_data_o,
  input logic                cfg_we_i,
  input logic                cfg_idx_i,
  input logic [31:0]         cfg_data_i
);
  import awtm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still in work");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.result_kind != 2'd3)
    else $error("illegal result kind");

  a_fail_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KindFailed |->
      out_data_o.current_threshold != '0)
    else $error("failure reported with threshold unarmed");

endmodule

bind adaptive_worker_timeout_monitor_unit awtm_checker u_awtm_checker (.*);

### tb/adaptive_worker_timeout_monitor_unit_tb.sv
module adaptive_worker_timeout_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awtm_pkg::*;

  localparam int NW = NWorkersDef;
  localparam logic [TimeBits-1:0] TMax = '1;
  localparam logic [1:0] ReqUnknown = 2'd3;

  // Behavioural copy of the monitor: statistics, thresholds and the queue of
  // results still owed by the block.
  class timeout_scoreboard;
    logic [TimeBits-1:0] start_t [NW];
    bit                  failed [NW];
    logic [31:0]         count;
    logic [63:0]         total;
    logic [63:0]         sqerr;
    logic [TimeBits-1:0] mean;
    logic [TimeBits-1:0] spread_v;
    logic [TimeBits-1:0] thr;
    logic [4:0]          nw;
    logic [31:0]         margin;
    awtm_out_t           owed [$];
    int                  errors;
    int                  n_checked;

    function new();
      foreach (start_t[i]) begin
        start_t[i] = '0;
        failed[i]  = 1'b0;
      end
      count = '0; total = '0; sqerr = '0;
      mean = '0; spread_v = '0; thr = '0;
      nw = NumWorkersRst;
      margin = MarginRst;
      errors = 0;
      n_checked = 0;
    endfunction

    function int active();
      if (nw < 1) return 1;
      if (nw > NW) return NW;
      return int'(nw);
    endfunction

    function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void owe(logic [1:0] kind, logic [3:0] id, logic fin);
      awtm_out_t r;
      r.result_kind       = kind;
      r.worker_id         = id;
      r.current_threshold = thr;
      r.last              = fin;
      owed.push_back(r);
    endfunction

    function void fold_span(int w, logic [TimeBits-1:0] t);
      logic [63:0] span, m, d, sq, t2;
      int n;
      n = active();
      span = 64'(t - start_t[w]);
      if (count != 32'hFFFF_FFFF) count++;
      total = sadd(total, span);
      m = total / 64'(count);
      mean = (m > 64'(TMax)) ? TMax : m[TimeBits-1:0];
      d = (span >= 64'(mean)) ? span - 64'(mean) : 64'(mean) - span;
      sq = (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : d * d;
      sqerr = sadd(sqerr, sq);
      spread_v = TimeBits'(root_floor(sqerr / 64'(count)));
      if (count >= 32'(n / 2)) begin
        t2 = sadd(64'(mean), sadd(64'(spread_v), 64'(spread_v)));
        t2 = sadd(t2, 64'(margin));
        thr = (t2 > 64'(TMax)) ? TMax : t2[TimeBits-1:0];
      end
      start_t[w] = t;
    endfunction

    // Work out every result that one accepted request will cause.
    function void note_request(awtm_in_t x);
      int w, n;
      logic [3:0] hit [$];
      w = int'(x.worker);
      n = active();
      if (x.req_type == ReqCheck) begin
        if (thr != 0) begin
          for (int i = 0; i < n && hit.size() < MaxRes; i++) begin
            if (failed[i] || x.time_value <= start_t[i]) continue;
            if (x.time_value - start_t[i] > thr) begin
              failed[i] = 1'b1;
              hit.push_back(4'(i));
            end
          end
        end
        if (hit.size() == 0) begin
          owe(KindRecorded, 4'd0, 1'b1);
        end else begin
          foreach (hit[j]) owe(KindFailed, hit[j], j == hit.size() - 1);
        end
      end else if (x.req_type == ReqUnknown) begin
        owe(KindIgnored, 4'd0, 1'b1);
      end else if (w >= n) begin
        owe(KindIgnored, x.worker, 1'b1);
      end else if (x.req_type == ReqLoad) begin
        start_t[w] = x.time_value;
        owe(KindRecorded, x.worker, 1'b1);
      end else if (failed[w] || x.time_value <= start_t[w]) begin
        owe(KindIgnored, x.worker, 1'b1);
      end else begin
        fold_span(w, x.time_value);
        owe(KindRecorded, x.worker, 1'b1);
      end
    endfunction

    function void check_result(awtm_out_t y);
      awtm_out_t e;
      n_checked++;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: kind %0d id %0d thr %0d last %0d",
                 $time, y.result_kind, y.worker_id, y.current_threshold, y.last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (y.result_kind !== e.result_kind) begin
        $display("%0t: result_kind expected %0d got %0d", $time, e.result_kind,
                 y.result_kind);
        errors++;
      end
      if (y.worker_id !== e.worker_id) begin
        $display("%0t: worker_id expected %0d got %0d", $time, e.worker_id, y.worker_id);
        errors++;
      end
      if (y.current_threshold !== e.current_threshold) begin
        $display("%0t: current_threshold expected %0d got %0d", $time,
                 e.current_threshold, y.current_threshold);
        errors++;
      end
      if (y.last !== e.last) begin
        $display("%0t: last expected %0d got %0d", $time, e.last, y.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  awtm_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  awtm_out_t   out_data_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;

  timeout_scoreboard sb = new();

  // receiver behaviour: 0 never stall, 1 random, 2 fixed duty pattern
  int          stall_mode = 0;
  bit          hold_go = 1'b0;
  int          hold_left = 0;
  int          rx_cyc = 0;
  int          n_sent = 0;
  logic [TimeBits-1:0] tnow;

  adaptive_worker_timeout_monitor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Receiver: check each transaction taken at this edge, then choose the next
  // stall. A long hold, once requested, overrides the normal pattern.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_go) begin
      hold_left = 3000;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 35);
        default: out_stall_i <= ((rx_cyc % 7) < 3);
      endcase
    end
    rx_cyc++;
  end

  // Offer one request and hold it until taken; note it on acceptance.
  task automatic send(logic [1:0] kind, logic [3:0] w, logic [TimeBits-1:0] t);
    awtm_in_t x;
    x.req_type   = kind;
    x.worker     = w;
    x.time_value = t;
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(x);
    n_sent++;
  endtask

  task automatic idle(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain everything owed, then leave a margin before touching registers.
  task automatic settle();
    idle(1);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CfgNumWorkers) sb.nw = val[4:0];
    else sb.margin = val;
  endtask

  // Random traffic: the largest share is updates on top of the current start
  // times, mostly well-formed, with loads, checks near or past the threshold, and some noise.
  task automatic random_traffic(int items);
    int burst, pick, w;
    logic [TimeBits-1:0] t;
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (burst == 0) begin
        idle($urandom_range(1, 6));
        burst = $urandom_range(1, 12);
      end
      burst--;
      tnow = tnow + TimeBits'($urandom_range(1, 4096));
      pick = $urandom_range(0, 99);
      w = $urandom_range(0, NW - 1);
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) t = sb.start_t[w] - TimeBits'($urandom_range(0, 3));
        else t = sb.start_t[w] + TimeBits'($urandom_range(1, 20000));
        send(ReqUpdate, 4'(w), t);
      end else if (pick < 60) begin
        send(ReqLoad, 4'(w), tnow);
      end else if (pick < 80) begin
        if ($urandom_range(0, 2) == 0) t = tnow + sb.thr + TimeBits'($urandom_range(1, 5000));
        else t = tnow + TimeBits'($urandom_range(0, 100000));
        send(ReqCheck, 4'(w), t);
      end else if (pick < 86) begin
        send(ReqUnknown, 4'(w), TimeBits'({$urandom(), $urandom()}));
      end else begin
        // noise: any type, any worker, any time
        send(2'($urandom_range(0, 3)), 4'(w), TimeBits'({$urandom(), $urandom()}));
      end
    end
  endtask

  initial begin
    #4ms;
    $display("adaptive_worker_timeout_monitor_unit_tb: done, errors");
    $finish;
  end

  initial begin
    int w;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgNumWorkers;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown type and a check before arming, then load every
    // worker so that no later scan touches an unset start time.
    send(ReqUnknown, 4'd9, TMax);
    send(ReqCheck, 4'd0, 48'd5);
    for (int i = 0; i < NW; i++) send(ReqLoad, 4'(i), 48'd1000 + 48'(i));
    send(ReqUpdate, 4'd0, 48'd1000);
    send(ReqUpdate, 4'd1, 48'd999);
    for (int i = 2; i < 10; i++) send(ReqUpdate, 4'(i), 48'd1000 + 48'(i) + 48'(500 + i * 37));
    send(ReqCheck, 4'd0, 48'd0);
    tnow = 48'd1010 + sb.thr + 48'd1;
    send(ReqCheck, 4'd15, tnow);
    send(ReqLoad, 4'd0, tnow);
    send(ReqUpdate, 4'd0, tnow + 48'd100);
    settle();

    // One worker in use, no margin.
    stall_mode = 1;
    write_reg(CfgNumWorkers, 32'd0);
    write_reg(CfgMargin, 32'd0);
    random_traffic(12);
    settle();

    // A handful of workers, random margin.
    stall_mode = 2;
    write_reg(CfgNumWorkers, 32'd5);
    write_reg(CfgMargin, $urandom());
    random_traffic(15);
    settle();

    // Count above the worker total clamps; widest margin.
    stall_mode = 0;
    write_reg(CfgNumWorkers, 32'd31);
    write_reg(CfgMargin, 32'hFFFF_FFFF);
    random_traffic(15);
    settle();

    // Full set, no margin: hold the output off while requests keep coming so
    // that the block backs up, then carry on with random traffic.
    stall_mode = 1;
    write_reg(CfgNumWorkers, 32'd16);
    write_reg(CfgMargin, 32'd0);
    hold_go = 1'b1;
    for (int i = 0; i < 10; i++) send(ReqUnknown, 4'(i), tnow);
    random_traffic(20);

    // Saturate the statistics from a start time of zero.
    w = -1;
    for (int i = NW - 1; i >= 0; i--) if (!sb.failed[i]) w = i;
    if (w >= 0) begin
      send(ReqLoad, 4'(w), 48'd0);
      send(ReqUpdate, 4'(w), TMax);
    end
    send(ReqCheck, 4'd0, TMax);

    idle(1);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results over five register settings.",
             n_sent, sb.n_checked);
    $display("Final threshold %0d after %0d recorded spans.", sb.thr, sb.count);
    if (sb.errors == 0) begin
      $display("adaptive_worker_timeout_monitor_unit_tb: done, clean");
    end else begin
      $display("adaptive_worker_timeout_monitor_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
